FILE: sv/bresenham_line_stepper_top_assert.svh
// Assertion macros shared by the line stepper.
`ifndef BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH

// Check a property in the same cycle, outside reset.
`define BLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a property in the cycle after its trigger, outside reset.
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bls_pkg.sv
`default_nettype none
package bls_pkg;

  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } bls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;
    logic last_step;
  } bls_status_t;

  // Move one coordinate by one unit, wrapping at the coordinate width.
  function automatic coord_t step_axis(coord_t v, logic neg);
    coord_t r;
    if (neg) begin
      r = v - coord_t'(1);
    end else begin
      r = v + coord_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bls_ctrl.sv
`default_nettype none
module bls_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire bls_pkg::bls_status_t status_i,
  output bls_pkg::bls_cmd_t       cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Take a request only when no line is being walked.
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // While a line is walked, issue one pixel beat whenever the output register is free or draining.
  always_comb begin
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.emit = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  end

  // Hold state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load && !status_i.zero_len) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_o.emit && status_i.last_step) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/bls_dpath.sv
`default_nettype none
module bls_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bls_pkg::bls_cmd_t   cmd_i,
  output bls_pkg::bls_status_t     status_o,
  input  wire bls_pkg::coord_t     start_x_i,
  input  wire bls_pkg::coord_t     start_y_i,
  input  wire bls_pkg::coord_t     end_x_i,
  input  wire bls_pkg::coord_t     end_y_i,
  output bls_pkg::coord_t          pixel_x_o,
  output bls_pkg::coord_t          pixel_y_o,
  output logic                     last_pixel_o
);

  bls_pkg::coord_t cur_x_q, cur_y_q;
  bls_pkg::coord_t major_q, minor_q;
  bls_pkg::coord_t steps_q;
  bls_pkg::err_t   err_q;
  logic            swap_q, xneg_q, yneg_q;
  bls_pkg::coord_t pix_x_q, pix_y_q;
  logic            last_q;

  bls_pkg::coord_t adx, ady, ld_major, ld_minor;
  logic            ld_xneg, ld_yneg, ld_swap;
  bls_pkg::err_t   ld_err;
  bls_pkg::err_t   err_adj, err_d;
  bls_pkg::coord_t cur_x_d, cur_y_d;
  logic            move_minor;

  // Set up deltas, directions and the starting decision value.
  always_comb begin
    ld_xneg  = !(end_x_i > start_x_i);
    ld_yneg  = !(end_y_i > start_y_i);
    adx      = ld_xneg ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ady      = ld_yneg ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    ld_swap  = ady > adx;
    ld_major = ld_swap ? ady : adx;
    ld_minor = ld_swap ? adx : ady;
    ld_err   = (bls_pkg::err_t'(ld_minor) << 1) - bls_pkg::err_t'(ld_major);
  end

  // Advance the cursor by one pixel and update the decision value.
  always_comb begin
    move_minor = !err_q[bls_pkg::ERR_BITS-1];
    err_adj    = move_minor ? (err_q - (bls_pkg::err_t'(major_q) << 1)) : err_q;
    err_d      = err_adj + (bls_pkg::err_t'(minor_q) << 1);
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    if (swap_q) begin
      cur_y_d = bls_pkg::step_axis(cur_y_q, yneg_q);
      if (move_minor) begin
        cur_x_d = bls_pkg::step_axis(cur_x_q, xneg_q);
      end
    end else begin
      cur_x_d = bls_pkg::step_axis(cur_x_q, xneg_q);
      if (move_minor) begin
        cur_y_d = bls_pkg::step_axis(cur_y_q, yneg_q);
      end
    end
  end

  always_comb begin
    status_o.zero_len  = (start_x_i == end_x_i) && (start_y_i == end_y_i);
    status_o.last_step = (steps_q == bls_pkg::coord_t'(1));
  end

  // Load or count down the step counter; clear it at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else if (cmd_i.load) begin
      steps_q <= ld_major;
    end else if (cmd_i.emit) begin
      steps_q <= steps_q - bls_pkg::coord_t'(1);
    end
  end

  // Load or advance the cursor and decision value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= start_x_i;
      cur_y_q <= start_y_i;
      major_q <= ld_major;
      minor_q <= ld_minor;
      err_q   <= ld_err;
      swap_q  <= ld_swap;
      xneg_q  <= ld_xneg;
      yneg_q  <= ld_yneg;
    end else if (cmd_i.emit) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
    end
  end

  // Capture the pixel beat into the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pix_x_q <= cur_x_q;
      pix_y_q <= cur_y_q;
      last_q  <= status_o.last_step;
    end
  end

  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = last_q;

endmodule
`default_nettype wire

FILE: sv/bresenham_line_stepper_top.sv
// Bresenham line stepper for all octants: a request beat carries a start and an end
// point, and the block returns the pixels from the start up to but not including the
// end, one beat each, the final one flagged by last_pixel_o; a request whose start
// equals its end returns nothing. A line of n = max(|dx|,|dy|) pixels occupies the
// stepper while it loads the request and then emits each pixel in turn, held back
// whenever the output side stalls, from the single cursor and decision-value update
// that runs once per pixel. The next request is taken in the cycle after the last
// pixel enters the output register, even while that pixel still waits there, and a
// zero-length request leaves the stepper idle.
`default_nettype none
module bresenham_line_stepper_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bls_pkg::coord_t     start_x_i,
  input  wire bls_pkg::coord_t     start_y_i,
  input  wire bls_pkg::coord_t     end_x_i,
  input  wire bls_pkg::coord_t     end_y_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bls_pkg::coord_t          pixel_x_o,
  output bls_pkg::coord_t          pixel_y_o,
  output logic                     last_pixel_o
);

  `include "bresenham_line_stepper_top_assert.svh"

  bls_pkg::bls_cmd_t    cmd;
  bls_pkg::bls_status_t status;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bls_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // A pixel beat always lands in the output register.
  `BLS_ASSERT_NEXT(a_emit_fills_out, cmd.emit, out_valid_o, "pixel beat lost")
  // Issuing the last pixel frees the stepper for the next request.
  `BLS_ASSERT_NEXT(a_last_frees, cmd.emit && status.last_step, in_ready_o && last_pixel_o,
                   "stepper not idle after last pixel")
  // A zero-length request leaves the stepper idle.
  `BLS_ASSERT_NEXT(a_zero_len_idle, cmd.load && status.zero_len, in_ready_o,
                   "zero-length request started a walk")
  // No pixel is issued while waiting for a request.
  `BLS_ASSERT_NOW(a_idle_quiet, in_ready_o, !cmd.emit, "pixel issued while idle")

endmodule
`default_nettype wire

FILE: test/bresenham_line_stepper_top_test.sv
`timescale 1ns / 1ps
module bresenham_line_stepper_top_test;

  typedef bls_pkg::coord_t coord_t;

  // How a request row gets its reference pixels.
  typedef enum logic [1:0] {
    ROW_TRACE,   // walk the line in the local tracer
    ROW_EMPTY,   // zero-length line, no beats at all
    ROW_SINGLE   // one beat, given in the row
  } row_kind_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef struct packed {
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    row_kind_e kind;
    pixel_t    lone;
  } line_req_t;

  localparam int RANDOM_LINES = 500;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 19;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_t pending_pixels[$];
  pixel_t head_pixel;
  int     fail_count = 0;
  int     idle_cycles = 0;
  logic   calm = 1'b0;

  // Tracer state, rebuilt for every traced request.
  coord_t trace_x, trace_y, trace_major, trace_minor, trace_left;
  logic   trace_steep, trace_xneg, trace_yneg;
  int     trace_dec;

  // Hand-checked rows: extremes, one per octant, axis-aligned and tie lines.
  line_req_t directed_lines [0:24] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  ROW_EMPTY,  '{6'd0,  6'd0, 1'b0}},
    '{6'd63, 6'd63, 6'd63, 6'd63, ROW_EMPTY,  '{6'd0,  6'd0, 1'b0}},
    '{6'd0,  6'd0,  6'd1,  6'd0,  ROW_SINGLE, '{6'd0,  6'd0, 1'b1}},
    '{6'd63, 6'd63, 6'd62, 6'd63, ROW_SINGLE, '{6'd63, 6'd63, 1'b1}},
    '{6'd0,  6'd0,  6'd1,  6'd1,  ROW_SINGLE, '{6'd0,  6'd0, 1'b1}},
    '{6'd63, 6'd0,  6'd62, 6'd1,  ROW_SINGLE, '{6'd63, 6'd0, 1'b1}},
    '{6'd0,  6'd0,  6'd63, 6'd0,  ROW_TRACE,  '0},
    '{6'd63, 6'd0,  6'd0,  6'd0,  ROW_TRACE,  '0},
    '{6'd0,  6'd0,  6'd0,  6'd63, ROW_TRACE,  '0},
    '{6'd0,  6'd63, 6'd0,  6'd0,  ROW_TRACE,  '0},
    '{6'd0,  6'd0,  6'd63, 6'd63, ROW_TRACE,  '0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  ROW_TRACE,  '0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  ROW_TRACE,  '0},
    '{6'd63, 6'd0,  6'd0,  6'd63, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd40, 6'd35, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd35, 6'd40, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd24, 6'd35, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd29, 6'd40, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd24, 6'd29, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd29, 6'd24, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd40, 6'd29, ROW_TRACE,  '0},
    '{6'd32, 6'd32, 6'd35, 6'd24, ROW_TRACE,  '0},
    '{6'd0,  6'd0,  6'd4,  6'd2,  ROW_TRACE,  '0},
    '{6'd10, 6'd10, 6'd30, 6'd20, ROW_TRACE,  '0},
    '{6'd21, 6'd42, 6'd42, 6'd21, ROW_TRACE,  '0}
  };

  bresenham_line_stepper_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walk one line with the integer decision value and queue its pixels.
  function automatic void trace_line(line_req_t req);
    trace_xneg  = !(req.ex > req.sx);
    trace_yneg  = !(req.ey > req.sy);
    trace_x     = req.sx;
    trace_y     = req.sy;
    trace_major = trace_xneg ? req.sx - req.ex : req.ex - req.sx;
    trace_minor = trace_yneg ? req.sy - req.ey : req.ey - req.sy;
    trace_steep = trace_minor > trace_major;
    if (trace_steep) begin
      {trace_major, trace_minor} = {trace_minor, trace_major};
    end
    trace_left = trace_major;
    trace_dec  = 2 * int'(trace_minor) - int'(trace_major);
    while (trace_left != 0) begin
      pending_pixels.push_back('{x: trace_x, y: trace_y, last: trace_left == 1});
      // a tie moves the minor axis too
      if (trace_dec >= 0) begin
        if (trace_steep) begin
          trace_x = trace_xneg ? trace_x - 1'b1 : trace_x + 1'b1;
        end else begin
          trace_y = trace_yneg ? trace_y - 1'b1 : trace_y + 1'b1;
        end
        trace_dec -= 2 * int'(trace_major);
      end
      if (trace_steep) begin
        trace_y = trace_yneg ? trace_y - 1'b1 : trace_y + 1'b1;
      end else begin
        trace_x = trace_xneg ? trace_x - 1'b1 : trace_x + 1'b1;
      end
      trace_dec += 2 * int'(trace_minor);
      trace_left--;
    end
  endfunction

  // Offer one request beat, hold it until taken, then queue its pixels.
  task automatic send_line(line_req_t req);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= req.sx;
    start_y_i  <= req.sy;
    end_x_i    <= req.ex;
    end_y_i    <= req.ey;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    case (req.kind)
      ROW_EMPTY: begin
      end
      ROW_SINGLE: begin
        pending_pixels.push_back(req.lone);
      end
      default: begin
        trace_line(req);
      end
    endcase
  endtask

  // Stall the pixel side at random, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every pixel beat against the oldest queued one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel (%0d,%0d) last=%0b", pixel_x_o, pixel_y_o, last_pixel_o);
        fail_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        if (pixel_x_o !== head_pixel.x) begin
          $error("pixel_x: expected %0d, got %0d", head_pixel.x, pixel_x_o);
          fail_count++;
        end
        if (pixel_y_o !== head_pixel.y) begin
          $error("pixel_y: expected %0d, got %0d", head_pixel.y, pixel_y_o);
          fail_count++;
        end
        if (last_pixel_o !== head_pixel.last) begin
          $error("last_pixel: expected %0b, got %0b", head_pixel.last, last_pixel_o);
          fail_count++;
        end
      end
    end
  end

  // Drop the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    line_req_t req;
    int        roll;
    int        lo;
    int        hi;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_lines[i]) begin
      send_line(directed_lines[i]);
    end

    for (int n = 0; n < RANDOM_LINES; n++) begin
      calm = (n >= 200) && (n < 280);
      // hold the sender back until every queued pixel has come out
      if (n == 300) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_pixels.size() != 0) begin
          @(posedge clk_i);
        end
      end
      req.kind = ROW_TRACE;
      req.lone = '0;
      req.sx   = coord_t'($urandom_range(63));
      req.sy   = coord_t'($urandom_range(63));
      roll     = $urandom_range(99);
      if (roll < 70) begin
        // mostly short lines around the start point
        lo = (req.sx > 8) ? req.sx - 8 : 0;
        hi = (req.sx < 55) ? req.sx + 8 : 63;
        req.ex = coord_t'($urandom_range(hi, lo));
        lo = (req.sy > 8) ? req.sy - 8 : 0;
        hi = (req.sy < 55) ? req.sy + 8 : 63;
        req.ey = coord_t'($urandom_range(hi, lo));
      end else if (roll < 90) begin
        req.ex = coord_t'($urandom_range(63));
        req.ey = coord_t'($urandom_range(63));
      end else if (roll < 95) begin
        req.ex = req.sx;
        req.ey = req.sy;
      end else begin
        req.sx = $urandom_range(1) ? 6'd63 : 6'd0;
        req.sy = $urandom_range(1) ? 6'd63 : 6'd0;
        req.ex = $urandom_range(1) ? 6'd63 : 6'd0;
        req.ey = $urandom_range(1) ? 6'd63 : 6'd0;
      end
      send_line(req);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixels never arrived", pending_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: bresenham_line_stepper_top.f
+incdir+sv
sv/bls_pkg.sv
sv/bls_ctrl.sv
sv/bls_dpath.sv
sv/bresenham_line_stepper_top.sv
test/bresenham_line_stepper_top_test.sv
